FILE: hw/rtl/adpe_pkg.sv
package adpe_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned RegCount  = 16;
   localparam int unsigned AddrWidth = 4;

   localparam logic [DataWidth-1:0] DataMask = 32'hffff_ffff;
   localparam logic [DataWidth-1:0] SignBit  = 32'h8000_0000;

   typedef enum logic [3:0] {
      OP_AND = 4'd0,
      OP_EOR = 4'd1,
      OP_SUB = 4'd2,
      OP_RSB = 4'd3,
      OP_ADD = 4'd4,
      OP_TST = 4'd8,
      OP_TEQ = 4'd9,
      OP_CMP = 4'd10,
      OP_ORR = 4'd12,
      OP_MOV = 4'd13
   } opcode_type;

   typedef enum logic [1:0] {
      SH_LSL = 2'd0,
      SH_LSR = 2'd1,
      SH_ASR = 2'd2,
      SH_ROR = 2'd3
   } shift_kind_type;

   // register file write port
   typedef struct packed {
      logic                 en;
      logic [AddrWidth-1:0] addr;
      logic [DataWidth-1:0] data;
   } rf_write_type;

endpackage

FILE: hw/rtl/adpe_regfile.sv
// 16 x 32 register file: synchronous memory, two read ports, one write port.
// Per-entry valid bits give the all-zero reset; the last write is forwarded
// to a read issued at the same edge.
module adpe_regfile
   import adpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr_a,
   input  logic [AddrWidth-1:0] rd_addr_b,
   input  rf_write_type         wr,
   output logic [DataWidth-1:0] rd_data_a,
   output logic [DataWidth-1:0] rd_data_b
);

   logic [DataWidth-1:0] rf_mem [RegCount];

   logic [RegCount-1:0]  vld_ff;
   logic [RegCount-1:0]  vld_in;
   logic [DataWidth-1:0] q_a_ff;
   logic [DataWidth-1:0] q_b_ff;
   logic [AddrWidth-1:0] addr_a_ff;
   logic [AddrWidth-1:0] addr_b_ff;
   logic                 fwd_vld_ff;
   logic [AddrWidth-1:0] fwd_addr_ff;
   logic [DataWidth-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         rf_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         q_a_ff    <= rf_mem[rd_addr_a];
         q_b_ff    <= rf_mem[rd_addr_b];
         addr_a_ff <= rd_addr_a;
         addr_b_ff <= rd_addr_b;
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   // most recent write, always the newest value of its entry
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (wr.en) begin
            fwd_vld_ff <= 1'b1;
         end
      end
      if (wr.en) begin
         fwd_addr_ff <= wr.addr;
         fwd_data_ff <= wr.data;
      end
   end

   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == addr_a_ff)) begin
         rd_data_a = fwd_data_ff;
      end else if (vld_ff[addr_a_ff]) begin
         rd_data_a = q_a_ff;
      end else begin
         rd_data_a = '0;
      end
      if (fwd_vld_ff && (fwd_addr_ff == addr_b_ff)) begin
         rd_data_b = fwd_data_ff;
      end else if (vld_ff[addr_b_ff]) begin
         rd_data_b = q_b_ff;
      end else begin
         rd_data_b = '0;
      end
   end

endmodule

FILE: hw/rtl/arm_data_processing_execute.sv
// Channel  Dir  Handshake              Payload
// req      in   req_valid/req_stall    imm_flag opcode set_flags first_reg dest_reg
//                                      operand_two_field
// rsp      out  rsp_valid/rsp_stall    result_value reg_written flag_n flag_z flag_c
//
// The register file is read on the accept edge; the shifter and ALU run in
// the next cycle, and write back as the execute stage advances.
// One request per cycle while rsp_stall is low; register-file forwarding
// covers a request that reads the register written by the one just before it.
// Reset (synchronous, active high) clears the flags, the register valid bits
// and both pipeline valids. rsp_stall holds the output register; the
// execute stage stalls behind it, and req_stall rises only when it is full.
module arm_data_processing_execute
   import adpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_imm_flag,
   input  logic [3:0]           req_opcode,
   input  logic                 req_set_flags,
   input  logic [3:0]           req_first_reg,
   input  logic [3:0]           req_dest_reg,
   input  logic [11:0]          req_operand_two_field,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_result_value,
   output logic                 rsp_reg_written,
   output logic                 rsp_flag_n,
   output logic                 rsp_flag_z,
   output logic                 rsp_flag_c
);

   // ---------------- handshake / pipeline control ----------------
   logic req_accept;
   logic s1_advance;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // execute-stage request fields
   logic                 s1_imm_ff;
   logic [3:0]           s1_opcode_ff;
   logic                 s1_set_flags_ff;
   logic [AddrWidth-1:0] s1_dest_ff;
   logic [11:0]          s1_field_ff;

   // architectural flags
   logic flag_n_ff, flag_n_in;
   logic flag_z_ff, flag_z_in;
   logic flag_c_ff, flag_c_in;

   // output register
   logic [DataWidth-1:0] rsp_result_ff;
   logic                 rsp_written_ff;
   logic                 rsp_n_ff, rsp_z_ff, rsp_c_ff;

   logic [DataWidth-1:0] rn_data;
   logic [DataWidth-1:0] rm_data;
   rf_write_type         rf_wr;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flag_n_ff    <= 1'b0;
         flag_z_ff    <= 1'b0;
         flag_c_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flag_n_ff    <= flag_n_in;
         flag_z_ff    <= flag_z_in;
         flag_c_ff    <= flag_c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_imm_ff       <= req_imm_flag;
         s1_opcode_ff    <= req_opcode;
         s1_set_flags_ff <= req_set_flags;
         s1_dest_ff      <= req_dest_reg;
         s1_field_ff     <= req_operand_two_field;
      end
   end

   // ---------------- register file ----------------
   // Rn on port a, Rm (field bits 3..0) on port b; read on the accept edge.
   adpe_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_addr_a (req_first_reg),
      .rd_addr_b (req_operand_two_field[3:0]),
      .wr        (rf_wr),
      .rd_data_a (rn_data),
      .rd_data_b (rm_data)
   );

   // ---------------- barrel shifter ----------------
   logic [4:0]              sh_amt;
   shift_kind_type          sh_kind;
   logic [DataWidth-1:0]    imm_val;
   logic [2*DataWidth-1:0]  imm_rot;
   logic [2*DataWidth-1:0]  lsl_full;
   logic [2*DataWidth-1:0]  lsr_full;
   logic signed [2*DataWidth-1:0] asr_full;
   logic [2*DataWidth-1:0]  ror_full;
   logic [DataWidth-1:0]    op2;
   logic                    sh_c;

   assign sh_amt  = s1_field_ff[11:7];
   assign sh_kind = shift_kind_type'(s1_field_ff[6:5]);
   assign imm_val = {24'd0, s1_field_ff[7:0]};
   // rotate right by twice the 4-bit amount
   assign imm_rot  = {imm_val, imm_val} >> {s1_field_ff[11:8], 1'b0};
   // carry-out lands just outside the kept 32 bits (for ROR it is bit 31 of the result)
   assign lsl_full = {32'd0, rm_data} << sh_amt;
   assign lsr_full = {rm_data, 32'd0} >> sh_amt;
   assign asr_full = $signed({rm_data, 32'd0}) >>> sh_amt;
   assign ror_full = {rm_data, rm_data} >> sh_amt;

   always_comb begin
      op2  = rm_data;
      sh_c = 1'b0;
      if (s1_imm_ff) begin
         op2 = imm_rot[DataWidth-1:0];
      end else if (sh_amt != 5'd0) begin
         unique case (sh_kind)
            SH_LSL: begin
               op2  = lsl_full[DataWidth-1:0];
               sh_c = lsl_full[DataWidth];
            end
            SH_LSR: begin
               op2  = lsr_full[2*DataWidth-1:DataWidth];
               sh_c = lsr_full[DataWidth-1];
            end
            SH_ASR: begin
               op2  = asr_full[2*DataWidth-1:DataWidth];
               sh_c = asr_full[DataWidth-1];
            end
            SH_ROR: begin
               op2  = ror_full[DataWidth-1:0];
               sh_c = ror_full[DataWidth-1];
            end
         endcase
      end
   end

   // ---------------- ALU ----------------
   logic [DataWidth:0]   sum_full;
   logic [DataWidth:0]   sub_full;   // Rn - op2
   logic [DataWidth:0]   rsb_full;   // op2 - Rn
   logic [DataWidth-1:0] alu_res;
   logic                 alu_c;
   logic                 alu_ok;
   logic                 alu_wr;

   assign sum_full = {1'b0, rn_data} + {1'b0, op2};
   assign sub_full = {1'b0, rn_data} - {1'b0, op2};
   assign rsb_full = {1'b0, op2} - {1'b0, rn_data};

   always_comb begin
      alu_res = '0;
      alu_c   = 1'b0;
      alu_ok  = 1'b1;
      alu_wr  = 1'b1;
      unique case (s1_opcode_ff)
         OP_AND: begin
            alu_res = rn_data & op2;
            alu_c   = sh_c;
         end
         OP_EOR: begin
            alu_res = rn_data ^ op2;
            alu_c   = sh_c;
         end
         OP_SUB: begin
            alu_res = sub_full[DataWidth-1:0];
            alu_c   = !sub_full[DataWidth];   // not-borrow
         end
         OP_RSB: begin
            alu_res = rsb_full[DataWidth-1:0];
            alu_c   = !rsb_full[DataWidth];
         end
         OP_ADD: begin
            alu_res = sum_full[DataWidth-1:0];
            alu_c   = sum_full[DataWidth];
         end
         OP_TST: begin
            alu_res = rn_data & op2;
            alu_c   = sh_c;
            alu_wr  = 1'b0;
         end
         OP_TEQ: begin
            alu_res = rn_data ^ op2;
            alu_c   = sh_c;
            alu_wr  = 1'b0;
         end
         OP_CMP: begin
            alu_res = sub_full[DataWidth-1:0];
            alu_c   = !sub_full[DataWidth];
            alu_wr  = 1'b0;
         end
         OP_ORR: begin
            alu_res = rn_data | op2;
            alu_c   = sh_c;
         end
         OP_MOV: begin
            alu_res = op2;
            alu_c   = sh_c;
         end
         default: begin
            // undefined opcode: no write, no flag change, result zero
            alu_ok = 1'b0;
            alu_wr = 1'b0;
         end
      endcase
   end

   // ---------------- write back ----------------
   assign rf_wr.en   = s1_advance && alu_wr;
   assign rf_wr.addr = s1_dest_ff;
   assign rf_wr.data = alu_res;

   always_comb begin
      flag_n_in = flag_n_ff;
      flag_z_in = flag_z_ff;
      flag_c_in = flag_c_ff;
      if (s1_advance && alu_ok && s1_set_flags_ff) begin
         flag_n_in = (alu_res & SignBit) != '0;
         flag_z_in = (alu_res & DataMask) == '0;
         flag_c_in = alu_c;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_result_ff  <= alu_res;
         rsp_written_ff <= alu_wr;
         rsp_n_ff       <= flag_n_in;
         rsp_z_ff       <= flag_z_in;
         rsp_c_ff       <= flag_c_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_ff;
   assign rsp_reg_written  = rsp_written_ff;
   assign rsp_flag_n       = rsp_n_ff;
   assign rsp_flag_z       = rsp_z_ff;
   assign rsp_flag_c       = rsp_c_ff;

   // ---------------- assertions ----------------
   // input side only stalls behind a full execute stage
   a_stall_needs_s1: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req_stall with empty execute stage");

   // register write only as the instruction leaves execute
   a_write_on_advance: assert property (@(posedge clock) disable iff (reset)
      rf_wr.en |-> (s1_valid_ff && (!rsp_valid_ff || !rsp_stall)))
      else $error("register write without execute advance");

   // flags hold when the retiring instruction has S clear
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && !s1_set_flags_ff) |=>
         ($stable(flag_n_ff) && $stable(flag_z_ff) && $stable(flag_c_ff)))
      else $error("flags changed without S bit");

   // response reports the flags the instruction left behind
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      $past(s1_advance) |->
         (rsp_flag_n == flag_n_ff && rsp_flag_z == flag_z_ff && rsp_flag_c == flag_c_ff))
      else $error("response flags differ from architectural flags");

endmodule
